// ----- src/mbd_pkg.sv -----
package mbd_pkg;

   localparam logic [15:0] SCAN_LIMIT_RESET = 16'd4096;
   localparam logic [7:0]  SYNC_BYTE        = 8'hFF;
   localparam logic [7:0]  SYNC_MASK        = 8'hE0;
   localparam logic [1:0]  LAYER_III        = 2'b01;
   localparam logic [1:0]  VER_MPEG1        = 2'b11;
   localparam logic [1:0]  MODE_MONO        = 2'b11;
   localparam logic [23:0] TAG_ID3          = 24'h494433;
   localparam logic [31:0] MARK_XING        = 32'h58696E67;
   localparam logic [31:0] MARK_INFO        = 32'h496E666F;
   localparam logic [30:0] AVG_MAX          = 31'h7FFFFFFF;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_FRAME = 2'd1;
   localparam logic [1:0] KIND_AVG   = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [30:0] bitrate;
      logic [1:0]  rate_kind;
   } rsp_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_FRAME,
      SRC_FRAME_OPT,
      SRC_AVG
   } src_type;

   typedef struct packed {
      logic    step;
      logic    clear;
      logic    probe_load;
      logic    load_tag;
      logic    load_header;
      logic    fc_dec;
      logic    fc_inc;
      logic    fc_clear;
      logic    shift_frames;
      logic    shift_bytes;
      logic    div_start;
      logic    emit;
      src_type src;
   } cmd_type;

   typedef struct packed {
      logic pos_is_2;
      logic pos_is_9;
      logic id3_tag;
      logic id3_probe;
      logic scan_test;
      logic scan_exhausted;
      logic hdr_valid;
      logic fc_one;
      logic fc_three;
      logic marker_match;
      logic flags_ok;
      logic totals_nonzero;
      logic eof;
      logic div_done;
   } st_type;

   typedef struct packed {
      logic        valid;
      logic [18:0] bitrate;
      logic [15:0] hz;
      logic        mpeg1;
      logic [5:0]  side_m1;
   } hdr_type;

   function automatic logic [18:0] rate_mpeg1(input logic [3:0] idx);
      logic [18:0] r;
      unique case (idx)
         4'd1:    r = 19'd32000;
         4'd2:    r = 19'd40000;
         4'd3:    r = 19'd48000;
         4'd4:    r = 19'd56000;
         4'd5:    r = 19'd64000;
         4'd6:    r = 19'd80000;
         4'd7:    r = 19'd96000;
         4'd8:    r = 19'd112000;
         4'd9:    r = 19'd128000;
         4'd10:   r = 19'd160000;
         4'd11:   r = 19'd192000;
         4'd12:   r = 19'd224000;
         4'd13:   r = 19'd256000;
         4'd14:   r = 19'd320000;
         default: r = 19'd0;
      endcase
      return r;
   endfunction

   function automatic logic [18:0] rate_mpeg2(input logic [3:0] idx);
      logic [18:0] r;
      unique case (idx)
         4'd1:    r = 19'd8000;
         4'd2:    r = 19'd16000;
         4'd3:    r = 19'd24000;
         4'd4:    r = 19'd32000;
         4'd5:    r = 19'd40000;
         4'd6:    r = 19'd48000;
         4'd7:    r = 19'd56000;
         4'd8:    r = 19'd64000;
         4'd9:    r = 19'd80000;
         4'd10:   r = 19'd96000;
         4'd11:   r = 19'd112000;
         4'd12:   r = 19'd128000;
         4'd13:   r = 19'd144000;
         4'd14:   r = 19'd160000;
         default: r = 19'd0;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] sample_hz(input logic [1:0] ver, input logic [1:0] sri);
      logic [15:0] r;
      unique case ({ver, sri})
         4'b0000: r = 16'd11025;
         4'b0001: r = 16'd12000;
         4'b0010: r = 16'd8000;
         4'b1000: r = 16'd22050;
         4'b1001: r = 16'd24000;
         4'b1010: r = 16'd16000;
         4'b1100: r = 16'd44100;
         4'b1101: r = 16'd48000;
         4'b1110: r = 16'd32000;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   function automatic hdr_type check_header(input logic [31:0] w);
      hdr_type h;
      logic [1:0] ver;
      logic [3:0] bri;
      logic       mono;
      ver       = w[20:19];
      bri       = w[15:12];
      mono      = (w[7:6] == MODE_MONO);
      h.hz      = sample_hz(ver, w[11:10]);
      h.mpeg1   = (ver == VER_MPEG1);
      h.bitrate = h.mpeg1 ? rate_mpeg1(bri) : rate_mpeg2(bri);
      h.valid   = (w[31:24] == SYNC_BYTE) && ((w[23:16] & SYNC_MASK) == SYNC_MASK)
                  && (w[18:17] == LAYER_III) && (bri != 4'd0) && (bri != 4'd15)
                  && (h.hz != 16'd0);
      if (h.mpeg1) begin
         h.side_m1 = mono ? 6'd16 : 6'd31;
      end else begin
         h.side_m1 = mono ? 6'd8 : 6'd16;
      end
      return h;
   endfunction

endpackage

// ----- src/mbd_div.sv -----
module mbd_div
   import mbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] bytes_total,
   input  logic [15:0] hz,
   input  logic [31:0] frames,
   input  logic        mpeg1,
   output logic        done,
   output logic [30:0] quot
);

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_MUL,
      DIV_RUN
   } div_state_type;

   localparam int unsigned QBITS = 48;

   div_state_type state_ff;
   logic [5:0]  cnt_ff;
   logic        done_ff;
   logic [31:0] a_ff;
   logic [15:0] hz_ff;
   logic [31:0] frames_ff;
   logic        mpeg1_ff;
   logic [47:0] num_ff;
   logic [39:0] den_ff;
   logic [39:0] rem_ff;
   logic [30:0] quot_ff;

   logic [47:0] prod;
   logic [35:0] f9;
   logic [39:0] den_in;
   logic [40:0] rem_sh;
   logic [40:0] diff;
   logic        ge;
   logic [39:0] rem_in;
   logic [47:0] num_in;

   // bytes*8*hz / (frames*9*2^k): the factor 8 cancels into the shift
   assign prod   = a_ff * hz_ff;
   assign f9     = {1'b0, frames_ff, 3'b000} + {4'b0000, frames_ff};
   assign den_in = mpeg1_ff ? {f9, 4'b0000} : {1'b0, f9, 3'b000};
   assign rem_sh = {rem_ff, num_ff[47]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign ge     = (rem_sh >= {1'b0, den_ff});
   assign rem_in = ge ? diff[39:0] : rem_sh[39:0];
   assign num_in = {num_ff[46:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         cnt_ff   <= 6'd0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            DIV_IDLE: begin
               if (start) begin
                  a_ff      <= bytes_total;
                  hz_ff     <= hz;
                  frames_ff <= frames;
                  mpeg1_ff  <= mpeg1;
                  state_ff  <= DIV_MUL;
               end
            end
            DIV_MUL: begin
               num_ff   <= prod;
               den_ff   <= den_in;
               rem_ff   <= 40'd0;
               cnt_ff   <= 6'd0;
               state_ff <= DIV_RUN;
            end
            DIV_RUN: begin
               num_ff <= num_in;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(QBITS - 1)) begin
                  quot_ff  <= (|num_in[47:31]) ? AVG_MAX : num_in[30:0];
                  done_ff  <= 1'b1;
                  state_ff <= DIV_IDLE;
               end
            end
            default: state_ff <= DIV_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ----- src/mbd_datapath.sv -----
module mbd_datapath
   import mbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  cmd_type     cmd,
   output st_type      st,
   output rsp_type     rsp_data
);

   logic [15:0] limit_ff;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] win_ff, win_in;
   logic [29:0] ss_ff, ss_in;
   logic [18:0] ffb_ff, ffb_in, ffb_upd;
   logic [15:0] hz_ff, hz_in;
   logic        mpeg1_ff, mpeg1_in;
   logic [5:0]  fc_ff, fc_in;
   logic [31:0] frames_ff, frames_in;
   logic [23:0] bytes_ff, bytes_in;
   rsp_type     rsp_ff, rsp_in;

   logic [7:0]  b;
   logic [31:0] win_next;
   logic [31:0] bytes_next;
   logic [31:0] p;
   logic [32:0] scan_end;
   logic [29:0] tag_size;
   logic        div_done;
   logic [30:0] div_quot;
   hdr_type     hdr;

   assign b          = req_data.data_byte;
   assign win_next   = {win_ff[23:0], b};
   assign bytes_next = {bytes_ff, b};
   assign p          = pos_ff - 32'd4;
   assign scan_end   = {3'b000, ss_ff} + {17'd0, limit_ff};
   assign hdr        = check_header(win_ff);
   // raw shift-or of tag bytes 6..9, high bits not masked
   assign tag_size   = {1'b0, win_next[31:24], 21'd0} | {8'd0, win_next[23:16], 14'd0}
                     | {15'd0, win_next[15:8], 7'd0} | {22'd0, win_next[7:0]};

   always_comb begin
      st.pos_is_2       = (pos_ff == 32'd2);
      st.pos_is_9       = (pos_ff == 32'd9);
      st.id3_tag        = (win_next[23:0] == TAG_ID3);
      st.id3_probe      = ((pos_ff == 32'd7) || (pos_ff == 32'd8)) && (ffb_ff == 19'd0)
                          && ((pos_ff[15:0] - 16'd4) < limit_ff);
      st.scan_test      = (pos_ff >= 32'd4) && (pos_ff != '1) && (p >= {2'b00, ss_ff});
      st.scan_exhausted = ({1'b0, p} >= scan_end);
      st.hdr_valid      = hdr.valid;
      st.fc_one         = (fc_ff == 6'd1);
      st.fc_three       = (fc_ff == 6'd3);
      st.marker_match   = (win_next == MARK_XING) || (win_next == MARK_INFO);
      st.flags_ok       = (b[1:0] == 2'b11);
      st.totals_nonzero = (frames_ff != 32'd0) && (bytes_next != 32'd0);
      st.eof            = req_data.end_of_file;
      st.div_done       = div_done;
   end

   mbd_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.div_start),
      .bytes_total (bytes_next),
      .hz          (hz_ff),
      .frames      (frames_ff),
      .mpeg1       (mpeg1_ff),
      .done        (div_done),
      .quot        (div_quot)
   );

   always_comb begin
      if (cmd.load_header) begin
         ffb_upd = hdr.bitrate;
      end else if (cmd.probe_load) begin
         ffb_upd = hdr.valid ? hdr.bitrate : 19'd0;
      end else if (cmd.load_tag) begin
         ffb_upd = 19'd0;
      end else begin
         ffb_upd = ffb_ff;
      end

      pos_in    = pos_ff;
      win_in    = win_ff;
      ss_in     = ss_ff;
      hz_in     = hz_ff;
      mpeg1_in  = mpeg1_ff;
      fc_in     = fc_ff;
      frames_in = frames_ff;
      bytes_in  = bytes_ff;
      ffb_in    = ffb_upd;

      if (cmd.step) begin
         if (pos_ff != '1) begin
            pos_in = pos_ff + 32'd1;
         end
         win_in = win_next;
      end
      if (cmd.load_tag) begin
         ss_in = tag_size + 30'd10;
      end
      if (cmd.load_header) begin
         hz_in    = hdr.hz;
         mpeg1_in = hdr.mpeg1;
         fc_in    = hdr.side_m1;
      end else if (cmd.fc_clear) begin
         fc_in = 6'd0;
      end else if (cmd.fc_dec) begin
         fc_in = fc_ff - 6'd1;
      end else if (cmd.fc_inc) begin
         fc_in = fc_ff + 6'd1;
      end
      if (cmd.shift_frames) begin
         frames_in = {frames_ff[23:0], b};
      end
      if (cmd.shift_bytes) begin
         bytes_in = bytes_next[23:0];
      end
      if (cmd.clear) begin
         pos_in    = 32'd0;
         win_in    = 32'd0;
         ss_in     = 30'd0;
         ffb_in    = 19'd0;
         hz_in     = 16'd0;
         mpeg1_in  = 1'b0;
         fc_in     = 6'd0;
         frames_in = 32'd0;
         bytes_in  = 24'd0;
      end

      rsp_in = rsp_ff;
      if (cmd.emit) begin
         case (cmd.src)
            SRC_FRAME: begin
               rsp_in.bitrate   = {12'd0, ffb_upd};
               rsp_in.rate_kind = KIND_FRAME;
            end
            SRC_FRAME_OPT: begin
               rsp_in.bitrate   = {12'd0, ffb_upd};
               rsp_in.rate_kind = (ffb_upd != 19'd0) ? KIND_FRAME : KIND_NONE;
            end
            SRC_AVG: begin
               rsp_in.bitrate   = div_quot;
               rsp_in.rate_kind = KIND_AVG;
            end
            default: begin
               rsp_in.bitrate   = 31'd0;
               rsp_in.rate_kind = KIND_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= SCAN_LIMIT_RESET;
         pos_ff    <= 32'd0;
         win_ff    <= 32'd0;
         ss_ff     <= 30'd0;
         ffb_ff    <= 19'd0;
         hz_ff     <= 16'd0;
         mpeg1_ff  <= 1'b0;
         fc_ff     <= 6'd0;
         frames_ff <= 32'd0;
         bytes_ff  <= 24'd0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         pos_ff    <= pos_in;
         win_ff    <= win_in;
         ss_ff     <= ss_in;
         ffb_ff    <= ffb_in;
         hz_ff     <= hz_in;
         mpeg1_ff  <= mpeg1_in;
         fc_ff     <= fc_in;
         frames_ff <= frames_in;
         bytes_ff  <= bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- src/mbd_ctrl.sv -----
module mbd_ctrl
   import mbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  st_type  st,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      PH_LEAD,
      PH_ID3,
      PH_SCAN,
      PH_SKIP,
      PH_MARK,
      PH_FLAGS,
      PH_FRAMES,
      PH_BYTES,
      PH_DIV,
      PH_DONE
   } phase_type;

   phase_type state_ff, state_in, ph;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      div_eof_ff, div_eof_in;
   logic      accept;
   logic      sent;
   logic      go_div;

   assign req_ready = (state_ff != PH_DIV)
                      && (!rsp_valid_ff || rsp_ready || (state_ff == PH_DONE));
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd        = '0;
      cmd.src    = SRC_ZERO;
      state_in   = state_ff;
      div_eof_in = div_eof_ff;
      ph         = state_ff;
      sent       = 1'b0;
      go_div     = 1'b0;

      if (state_ff == PH_DIV) begin
         if (st.div_done) begin
            cmd.emit = 1'b1;
            cmd.src  = SRC_AVG;
            state_in = div_eof_ff ? PH_LEAD : PH_DONE;
         end
      end else if (accept) begin
         cmd.step = 1'b1;
         unique case (state_ff)
            PH_LEAD: begin
               if (st.pos_is_2) begin
                  ph = st.id3_tag ? PH_ID3 : PH_SCAN;
               end
            end
            PH_ID3: begin
               cmd.probe_load = st.id3_probe;
               if (st.pos_is_9) begin
                  cmd.load_tag = 1'b1;
                  ph           = PH_SCAN;
               end
            end
            PH_SCAN: begin
               if (st.scan_test) begin
                  if (st.scan_exhausted) begin
                     cmd.emit = 1'b1;
                     cmd.src  = SRC_ZERO;
                     sent     = 1'b1;
                  end else if (st.hdr_valid) begin
                     // counter loads side length less the current byte
                     cmd.load_header = 1'b1;
                     ph              = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               cmd.fc_dec = 1'b1;
               if (st.fc_one) begin
                  ph = PH_MARK;
               end
            end
            PH_MARK: begin
               if (st.fc_three) begin
                  cmd.fc_clear = 1'b1;
                  if (st.marker_match) begin
                     ph = PH_FLAGS;
                  end else begin
                     cmd.emit = 1'b1;
                     cmd.src  = SRC_FRAME;
                     sent     = 1'b1;
                  end
               end else begin
                  cmd.fc_inc = 1'b1;
               end
            end
            PH_FLAGS: begin
               if (st.fc_three) begin
                  cmd.fc_clear = 1'b1;
                  if (st.flags_ok) begin
                     ph = PH_FRAMES;
                  end else begin
                     cmd.emit = 1'b1;
                     cmd.src  = SRC_FRAME;
                     sent     = 1'b1;
                  end
               end else begin
                  cmd.fc_inc = 1'b1;
               end
            end
            PH_FRAMES: begin
               cmd.shift_frames = 1'b1;
               if (st.fc_three) begin
                  cmd.fc_clear = 1'b1;
                  ph           = PH_BYTES;
               end else begin
                  cmd.fc_inc = 1'b1;
               end
            end
            PH_BYTES: begin
               cmd.shift_bytes = 1'b1;
               if (st.fc_three) begin
                  cmd.fc_clear = 1'b1;
                  if (st.totals_nonzero) begin
                     cmd.div_start = 1'b1;
                     go_div        = 1'b1;
                  end else begin
                     cmd.emit = 1'b1;
                     cmd.src  = SRC_FRAME;
                     sent     = 1'b1;
                  end
               end else begin
                  cmd.fc_inc = 1'b1;
               end
            end
            PH_DONE: begin
               sent = 1'b1;
            end
            PH_DIV: begin
               sent = 1'b1;
            end
            default: begin
               sent = 1'b1;
            end
         endcase

         if (st.eof && !sent && !go_div) begin
            cmd.emit = 1'b1;
            sent     = 1'b1;
            if ((ph == PH_LEAD) || (ph == PH_SCAN)) begin
               cmd.src = SRC_ZERO;
            end else if (ph == PH_ID3) begin
               cmd.src = SRC_FRAME_OPT;
            end else begin
               cmd.src = SRC_FRAME;
            end
         end

         cmd.clear = st.eof;
         if (go_div) begin
            state_in   = PH_DIV;
            div_eof_in = st.eof;
         end else if (st.eof) begin
            state_in = PH_LEAD;
         end else if (sent) begin
            state_in = PH_DONE;
         end else begin
            state_in = ph;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PH_LEAD;
         rsp_valid_ff <= 1'b0;
         div_eof_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         div_eof_ff   <= div_eof_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/mp3_frame_bitrate_detector.sv -----
// channel  | ports                         | beat
// ---------+-------------------------------+------------------------------------
// request  | req_valid req_ready req_data  | one file byte, end_of_file on last
// response | rsp_valid rsp_ready rsp_data  | one bitrate and rate kind per file
// csr      | csr_wr_en csr_wr_data         | scan_limit, written at once
//
// One byte per cycle while parsing. An untaken response holds req_ready low, except for
// the bytes after the current file's own result, which are taken and dropped.
// An average-bitrate result holds req_ready low through the 32x16 multiply, the 48
// quotient bits from the one-bit-per-cycle divider and the posting of the beat.
// Synchronous reset clears the parser and sets scan_limit to 4096.
module mp3_frame_bitrate_detector
   import mbd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   cmd_type cmd;
   st_type  st;

   mbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .st        (st),
      .cmd       (cmd)
   );

   mbd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .st          (st),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- tb/mp3_frame_bitrate_detector_tb.sv -----
module mp3_frame_bitrate_detector_tb;
   import mbd_pkg::*;

   localparam int unsigned STALL_LIMIT  = 3000;
   localparam int unsigned DRAIN_CYCLES = 64;

   class bitrate_scoreboard;
      typedef enum bit [2:0] {
         PH_LEAD, PH_TAG, PH_SCAN, PH_SKIP, PH_MARK, PH_FLAGS, PH_FRAMES, PH_BYTES
      } parse_phase_type;

      rsp_type         expected_rates[$];
      int unsigned     failures, results, files;
      int unsigned     kind_none, kind_frame, kind_avg;
      bit [15:0]       scan_limit;
      bit [31:0]       position;
      bit [63:0]       tag_bytes;
      bit [63:0]       scan_base;
      bit [31:0]       window;
      parse_phase_type phase;
      bit [18:0]       frame_rate;
      bit [15:0]       sample_rate;
      bit              mpeg1;
      bit [5:0]        field_count;
      bit [31:0]       flags, frames, total;
      bit              sent;

      function new();
         scan_limit = SCAN_LIMIT_RESET;
         clear_file();
      endfunction

      function void clear_file();
         position = 0; tag_bytes = 0; scan_base = 0; window = 0; phase = PH_LEAD;
         frame_rate = 0; sample_rate = 0; mpeg1 = 0; field_count = 0;
         flags = 0; frames = 0; total = 0; sent = 0;
      endfunction

      function void set_scan_limit(bit [15:0] v);
         scan_limit = v;
      endfunction

      function int pending();
         return expected_rates.size();
      endfunction

      // frame bitrate of a header word, 0 if the header is not usable
      function bit [18:0] frame_rate_of(bit [31:0] w, output bit [15:0] hz,
                                        output bit one, output bit [5:0] side);
         bit [1:0]  ver, sri;
         bit [3:0]  bri;
         bit        mono;
         bit [18:0] kbps;
         bit [15:0] base;
         ver = w[20:19]; bri = w[15:12]; sri = w[11:10]; mono = (w[7:6] == MODE_MONO);
         hz = 0; one = 0; side = 0;
         if (w[31:24] != SYNC_BYTE || w[23:21] != 3'b111 || w[18:17] != LAYER_III)
            return '0;
         if (bri == 0 || bri == 15 || ver == 2'b01 || sri == 2'b11)
            return '0;
         case (sri)
            2'd0:    base = 16'd44100;
            2'd1:    base = 16'd48000;
            default: base = 16'd32000;
         endcase
         hz  = (ver == VER_MPEG1) ? base : (ver == 2'b10) ? base >> 1 : base >> 2;
         one = (ver == VER_MPEG1);
         if (one) begin
            if (bri <= 5)       kbps = 19'(24 + 8 * bri);
            else if (bri <= 9)  kbps = 19'(80 + 16 * (bri - 6));
            else if (bri <= 13) kbps = 19'(160 + 32 * (bri - 10));
            else                kbps = 19'd320;
            side = mono ? 6'd17 : 6'd32;
         end else begin
            if (bri <= 8) kbps = 19'(8 * bri);
            else          kbps = 19'(80 + 16 * (bri - 9));
            side = mono ? 6'd9 : 6'd17;
         end
         return 19'(kbps * 1000);
      endfunction

      function void push_result(bit [30:0] rate, logic [1:0] kind);
         rsp_type e;
         e.bitrate   = rate;
         e.rate_kind = kind;
         expected_rates.insert(expected_rates.size(), e);
         sent = 1;
         if (kind == KIND_NONE)       kind_none++;
         else if (kind == KIND_FRAME) kind_frame++;
         else                         kind_avg++;
      endfunction

      function void note_byte(req_type r);
         bit [7:0]  b;
         bit [31:0] q, t, sz;
         bit [63:0] p, num, den, avg;
         bit [18:0] br;
         bit [15:0] hz;
         bit        one;
         bit [5:0]  side;
         b = r.data_byte;
         q = position;
         if (!sent) begin
            if (q < 10) tag_bytes = {tag_bytes[55:0], b};
            if (phase == PH_LEAD && q == 2) begin
               phase = (tag_bytes[23:0] == TAG_ID3) ? PH_TAG : PH_SCAN;
               scan_base = 0;
            end else if (phase == PH_TAG) begin
               if ((q == 7 || q == 8) && frame_rate == 0 && q - 4 < scan_limit)
                  frame_rate = frame_rate_of(window, hz, one, side);
               if (q == 9) begin
                  t  = tag_bytes[31:0];
                  sz = (32'(t[31:24]) << 21) | (32'(t[23:16]) << 14) |
                       (32'(t[15:8]) << 7) | 32'(t[7:0]);
                  scan_base  = 64'd10 + 64'(sz);
                  frame_rate = 0;
                  phase      = PH_SCAN;
               end
            end
            if (phase == PH_SCAN && q >= 4 && q != 32'hFFFFFFFF) begin
               p = 64'(q) - 64'd4;
               if (p >= scan_base) begin
                  if (p - scan_base >= 64'(scan_limit)) begin
                     push_result('0, KIND_NONE);
                  end else begin
                     br = frame_rate_of(window, hz, one, side);
                     if (br != 0) begin
                        frame_rate  = br;
                        sample_rate = hz;
                        mpeg1       = one;
                        field_count = side;
                        phase       = PH_SKIP;
                     end
                  end
               end
            end
            window = {window[23:0], b};
            if (!sent) begin
               case (phase)
                  PH_SKIP: begin
                     field_count = 6'(field_count - 1);
                     if (field_count == 0) phase = PH_MARK;
                  end
                  PH_MARK: begin
                     field_count++;
                     if (field_count == 4) begin
                        field_count = 0;
                        if (window == MARK_XING || window == MARK_INFO) phase = PH_FLAGS;
                        else push_result(31'(frame_rate), KIND_FRAME);
                     end
                  end
                  PH_FLAGS: begin
                     flags = {flags[23:0], b};
                     field_count++;
                     if (field_count == 4) begin
                        field_count = 0;
                        if (flags[1:0] == 2'b11) phase = PH_FRAMES;
                        else push_result(31'(frame_rate), KIND_FRAME);
                     end
                  end
                  PH_FRAMES: begin
                     frames = {frames[23:0], b};
                     field_count++;
                     if (field_count == 4) begin
                        field_count = 0;
                        phase = PH_BYTES;
                     end
                  end
                  PH_BYTES: begin
                     total = {total[23:0], b};
                     field_count++;
                     if (field_count == 4) begin
                        field_count = 0;
                        if (frames != 0 && total != 0) begin
                           num = 64'(total) * 8 * 64'(sample_rate);
                           den = 64'(frames) * (mpeg1 ? 64'd1152 : 64'd576);
                           avg = num / den;
                           if (avg > 64'(AVG_MAX)) avg = 64'(AVG_MAX);
                           push_result(avg[30:0], KIND_AVG);
                        end else begin
                           push_result(31'(frame_rate), KIND_FRAME);
                        end
                     end
                  end
                  default: ;
               endcase
            end
            if (r.end_of_file && !sent) begin
               if (phase == PH_LEAD || phase == PH_SCAN) push_result('0, KIND_NONE);
               else if (phase == PH_TAG)
                  push_result(31'(frame_rate), (frame_rate != 0) ? KIND_FRAME : KIND_NONE);
               else push_result(31'(frame_rate), KIND_FRAME);
            end
         end
         if (position != 32'hFFFFFFFF) position++;
         if (r.end_of_file) begin
            files++;
            clear_file();
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_rates.size() == 0) begin
            if (failures < 10)
               $display("unexpected result beat: bitrate %0d kind %0d",
                        got.bitrate, got.rate_kind);
            failures++;
            return;
         end
         want = expected_rates.pop_front();
         if (got.bitrate !== want.bitrate || got.rate_kind !== want.rate_kind) begin
            if (failures < 10)
               $display("result %0d: expected bitrate %0d kind %0d, got bitrate %0d kind %0d",
                        results, want.bitrate, want.rate_kind, got.bitrate, got.rate_kind);
            failures++;
         end
         results++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   bitrate_scoreboard sb = new();
   bit [7:0]    file_bytes[$];
   int unsigned bytes_sent = 0;
   int unsigned hold_cycles = 0;
   int unsigned idle_cycles = 0;
   bit [15:0]   cur_limit = SCAN_LIMIT_RESET;

   mp3_frame_bitrate_detector dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) sb.set_scan_limit(csr_wr_data);
         if (req_valid && req_ready) sb.note_byte(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("timeout: no beat for %0d cycles", STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: random stalls, steady stretches, and one long hold-off on request
   initial begin : receiver
      int unsigned gap;
      bit          steady;
      steady = 0;
      forever begin
         if ($urandom_range(0, 19) == 0) steady = !steady;
         if (hold_cycles != 0) begin
            gap = hold_cycles;
            hold_cycles = 0;
         end else begin
            gap = steady ? 0 : $urandom_range(0, 9);
         end
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_file(int unsigned keep, bit rush);
      int unsigned n, gap, i;
      bit          steady;
      req_type     beat;
      n = (keep != 0 && keep < file_bytes.size()) ? keep : file_bytes.size();
      steady = rush || ($urandom_range(0, 3) == 0);
      for (i = 0; i < n; i++) begin
         gap = steady ? 0 : $urandom_range(0, 9);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         beat.data_byte   = file_bytes[i];
         beat.end_of_file = (i == n - 1);
         req_valid <= 1'b1;
         req_data  <= beat;
         do @(posedge clock); while (!req_ready);
         bytes_sent++;
      end
      file_bytes.delete();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_scan_limit(bit [15:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_limit = v;
   endtask

   task automatic add_byte(bit [7:0] v);
      file_bytes.insert(file_bytes.size(), v);
   endtask

   task automatic put_word(bit [31:0] w);
      add_byte(w[31:24]);
      add_byte(w[23:16]);
      add_byte(w[15:8]);
      add_byte(w[7:0]);
   endtask

   task automatic put_noise(int unsigned n);
      repeat (n) add_byte(8'($urandom));
   endtask

   task automatic put_tag(bit [31:0] size);
      int unsigned raw;
      add_byte(TAG_ID3[23:16]);
      add_byte(TAG_ID3[15:8]);
      add_byte(TAG_ID3[7:0]);
      put_noise(3);
      put_word(size);
      raw = (32'(size[31:24]) << 21) | (32'(size[23:16]) << 14) |
            (32'(size[15:8]) << 7) | 32'(size[7:0]);
      if (raw <= 300) put_noise(raw);
   endtask

   function automatic bit [31:0] make_header(bit [1:0] ver, bit [3:0] bri, bit [1:0] sri,
                                             bit [1:0] mode);
      return {SYNC_BYTE, 3'b111, ver, LAYER_III, 1'b1, bri, sri, 2'b00, mode, 6'b0};
   endfunction

   function automatic bit [31:0] random_header();
      bit [1:0]  ver, sri;
      bit [3:0]  bri;
      bit [31:0] w;
      case ($urandom_range(0, 9))
         0:       ver = 2'b01;
         1, 2, 3: ver = 2'b00;
         4, 5, 6: ver = 2'b10;
         default: ver = VER_MPEG1;
      endcase
      case ($urandom_range(0, 19))
         0:       bri = 4'd0;
         1:       bri = 4'd15;
         default: bri = 4'($urandom_range(1, 14));
      endcase
      sri = ($urandom_range(0, 9) == 0) ? 2'b11 : 2'($urandom_range(0, 2));
      w = {SYNC_BYTE, 3'b111, ver, LAYER_III, 1'($urandom), bri, sri, 2'($urandom),
           8'($urandom)};
      if ($urandom_range(0, 9) == 0) w = w ^ (32'h1 << $urandom_range(8, 31));
      return w;
   endfunction

   function automatic bit [31:0] random_total();
      case ($urandom_range(0, 6))
         0:       return 0;
         1:       return $urandom_range(1, 3);
         2, 3:    return $urandom;
         default: return $urandom_range(1, 5000000);
      endcase
   endfunction

   // header, side info, marker, flags, frame and byte totals
   task automatic put_frame(bit [31:0] hdr, bit [31:0] marker, bit [31:0] fl,
                            bit [31:0] nframes, bit [31:0] nbytes);
      bit mono;
      mono = (hdr[7:6] == MODE_MONO);
      put_word(hdr);
      if (hdr[20:19] == VER_MPEG1) put_noise(mono ? 17 : 32);
      else                         put_noise(mono ? 9 : 17);
      put_word(marker);
      put_word(fl);
      put_word(nframes);
      put_word(nbytes);
   endtask

   task automatic random_file();
      int unsigned sel, keep;
      bit [31:0]   marker, size;
      sel  = $urandom_range(0, 19);
      keep = 0;
      if (sel < 13) begin
         if ($urandom_range(0, 9) < 4) begin
            case ($urandom_range(0, 9))
               0, 1:    size = $urandom;
               2, 3:    size = {23'h0, 1'($urandom), 8'($urandom)};
               default: size = $urandom_range(0, 40);
            endcase
            put_tag(size);
         end
         put_noise($urandom_range(0, (cur_limit < 40) ? cur_limit + 1 : 12));
         sel = $urandom_range(0, 19);
         marker = (sel < 9) ? MARK_XING : (sel < 16) ? MARK_INFO : $urandom;
         put_frame(random_header(), marker,
                   ($urandom_range(0, 4) != 0) ? ($urandom | 32'h3) : $urandom,
                   random_total(), random_total());
         put_noise($urandom_range(0, 5));
         if ($urandom_range(0, 4) == 0) keep = $urandom_range(1, file_bytes.size());
      end else if (sel < 16) begin
         put_noise($urandom_range(5, 40));
      end else if (sel < 18) begin
         put_word({TAG_ID3, 8'($urandom)});
         if ($urandom_range(0, 1) == 0) file_bytes.pop_back();
         put_word(random_header());
         put_noise($urandom_range(0, 2));
         keep = $urandom_range(1, file_bytes.size());
      end else begin
         put_noise($urandom_range(1, 4));
      end
      send_file(keep, 0);
   endtask

   task automatic random_run(int unsigned budget);
      int unsigned start;
      start = bytes_sent;
      while (bytes_sent - start < budget) random_file();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed files at the reset scan limit
      file_bytes = '{8'h00};
      send_file(0, 0);
      file_bytes = '{8'h49, 8'h44};
      send_file(0, 0);
      put_frame(make_header(VER_MPEG1, 9, 0, 2'b00), MARK_XING, 32'h3, 100, 417960);
      put_noise(3);
      send_file(0, 0);
      put_frame(make_header(2'b10, 1, 1, MODE_MONO), MARK_INFO, 32'hF, 0, 5000);
      send_file(0, 0);
      put_frame(make_header(2'b00, 14, 2, 2'b00), MARK_XING, 32'h1, 10, 10);
      send_file(0, 0);
      put_frame(make_header(VER_MPEG1, 14, 1, MODE_MONO), 32'h12345678, 32'h3, 1, 1);
      put_noise(5);
      send_file(0, 0);
      put_frame(make_header(VER_MPEG1, 1, 1, 2'b01), MARK_XING, 32'hFFFFFFFF, 1,
                32'hFFFFFFFF);
      send_file(0, 0);
      put_frame(make_header(VER_MPEG1, 5, 0, 2'b10), MARK_INFO, 32'h3, 500, 0);
      send_file(0, 0);
      put_tag(5);
      put_frame(make_header(2'b00, 8, 0, MODE_MONO), MARK_XING, 32'h3, 1, 1);
      send_file(23, 0);
      // tag opening cut short, header at offset 3 then 4
      file_bytes = '{8'h49, 8'h44, 8'h33};
      put_word(32'hFFFB9064);
      add_byte(8'h00);
      send_file(0, 0);
      file_bytes = '{8'h49, 8'h44, 8'h33, 8'h00};
      put_word(32'hFFFB9064);
      add_byte(8'h55);
      send_file(0, 0);
      put_word(32'hFFFBF000);
      put_word(32'hFFFD9000);
      put_word(32'hFFEB9000);
      put_word(32'hFFFB9C00);
      put_word(32'hFEFB9000);
      put_frame(make_header(VER_MPEG1, 9, 0, 2'b00), MARK_INFO, 32'h3, 7, 999999);
      send_file(0, 0);
      repeat (20) add_byte(8'($urandom_range(0, 254)));
      send_file(0, 0);

      write_scan_limit(16'd0);
      file_bytes = '{8'h49, 8'h44, 8'h33};
      put_word(32'hFFFB9064);
      add_byte(8'h00);
      send_file(0, 0);
      put_word(32'hFFFB9064);
      put_noise(2);
      send_file(0, 0);

      write_scan_limit(16'd1);
      put_frame(make_header(VER_MPEG1, 9, 0, 2'b00), MARK_XING, 32'h3, 50, 60000);
      send_file(0, 0);
      file_bytes = '{8'h00};
      put_word(32'hFFFB9064);
      put_noise(3);
      send_file(0, 0);
      put_tag(0);
      put_frame(make_header(2'b10, 4, 2, 2'b00), MARK_INFO, 32'h3, 3, 4000);
      send_file(0, 0);

      write_scan_limit(16'hFFFF);
      random_run(180);
      write_scan_limit(16'd1);
      random_run(150);
      write_scan_limit(16'($urandom_range(2, 40)));
      random_run(180);

      // receiver holds off while tiny files keep coming, so the block backs up
      write_scan_limit(SCAN_LIMIT_RESET);
      hold_cycles = 400;
      repeat (60) begin
         put_noise($urandom_range(1, 3));
         send_file(0, 1);
      end
      random_run(180);

      write_scan_limit(16'($urandom_range(1, 65535)));
      random_run(180);
      write_scan_limit(16'($urandom_range(2, 40)));
      random_run(180);

      drain();
      $display("covered %0d files in %0d bytes under scan limits 0, 1, 4096, 65535 and random",
               sb.files, bytes_sent);
      $display("results: %0d none found, %0d header bitrate, %0d Xing/Info average",
               sb.kind_none, sb.kind_frame, sb.kind_avg);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- mp3_frame_bitrate_detector.f -----
src/mbd_pkg.sv
src/mbd_div.sv
src/mbd_datapath.sv
src/mbd_ctrl.sv
src/mp3_frame_bitrate_detector.sv
tb/mp3_frame_bitrate_detector_tb.sv
